// ===== rtl/core/stream_find_and_replace_macros.svh =====
// Assertion macros shared by the find-and-replace RTL.
`ifndef STREAM_FIND_AND_REPLACE_MACROS_SVH
`define STREAM_FIND_AND_REPLACE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SFR_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFR_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/core/sfr_pkg.sv =====
// Shared constants and controller/datapath interface types for find-and-replace.
`default_nettype none

package sfr_pkg;

    localparam int FIND_MAX_DEF  = 16;
    localparam int SUBST_MAX_DEF = 16;
    localparam int CHAR_W        = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_char;
        logic load_window;
        logic advance;
        logic clear_match;
        logic load_subst;
        logic emit_window;
        logic emit_subst;
        logic commit_shift;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_term;
        logic bypass;
        logic hit;
        logic full_match;
        logic subst_empty;
        logic out_ready;
        logic window_one;
        logic subst_one;
        logic cand_ok;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/core/sfr_datapath.sv =====
// Datapath: configuration registers, match count, byte window, output register.
`default_nettype none
`include "stream_find_and_replace_macros.svh"

module sfr_datapath #(
    parameter int FIND_MAX  = sfr_pkg::FIND_MAX_DEF,
    parameter int SUBST_MAX = sfr_pkg::SUBST_MAX_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [sfr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [sfr_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire  [sfr_pkg::CHAR_W-1:0]         i_char,
    input  wire  sfr_pkg::t_dp_cmd             i_cmd,
    output sfr_pkg::t_dp_status                o_status,
    input  wire                                i_out_ready,
    output logic                               o_out_valid,
    output logic [sfr_pkg::CHAR_W-1:0]         o_out_char,
    output logic                               o_out_last
);
    import sfr_pkg::*;

    localparam int FIW         = (FIND_MAX > 1) ? $clog2(FIND_MAX) : 1;
    localparam int FIND_DEPTH  = 1 << FIW;
    localparam int SIW         = (SUBST_MAX > 1) ? $clog2(SUBST_MAX) : 1;
    localparam int SUBST_DEPTH = 1 << SIW;
    localparam int FLW         = $clog2(FIND_MAX + 1);
    localparam int SLW         = $clog2(SUBST_MAX + 1);
    localparam int WIN         = FIND_MAX;

    localparam logic [CFG_IDX_W-1:0] REG_FIND_LO  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FIND_HI  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_FIND_LEN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SUB_LO   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_SUB_HI   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_SUB_LEN  = CFG_IDX_W'(5);

    logic [CHAR_W-1:0] r_find  [FIND_DEPTH];
    logic [CHAR_W-1:0] r_subst [SUBST_DEPTH];
    logic [FLW-1:0]    r_flen;
    logic [SLW-1:0]    r_slen;
    logic [FLW-1:0]    r_match;
    logic [CHAR_W-1:0] r_char;
    logic [CHAR_W-1:0] r_win   [WIN];
    logic [FLW-1:0]    r_rem;
    logic [SIW-1:0]    r_sub_idx;
    logic [SLW-1:0]    r_sub_left;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;

    logic [FLW-1:0]    w_flen_clamp;
    logic [SLW-1:0]    w_slen_clamp;
    logic [FLW-1:0]    w_rem_next;
    logic              w_cand_ok;
    logic              w_emit;

    // Lengths are clamped on write, so the stored value is always in range.
    assign w_flen_clamp = (i_cfg_wdata[4:0] > 5'(FIND_MAX))  ? FLW'(FIND_MAX)
                                                              : FLW'(i_cfg_wdata[4:0]);
    assign w_slen_clamp = (i_cfg_wdata[4:0] > 5'(SUBST_MAX)) ? SLW'(SUBST_MAX)
                                                              : SLW'(i_cfg_wdata[4:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < FIND_DEPTH; j++) begin
                r_find[j] <= '0;
            end
            for (int j = 0; j < SUBST_DEPTH; j++) begin
                r_subst[j] <= '0;
            end
            r_flen <= '0;
            r_slen <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FIND_LO: begin
                    for (int j = 0; j < 8; j++) begin
                        if (j < FIND_MAX) r_find[FIW'(j)] <= i_cfg_wdata[8*j +: 8];
                    end
                end
                REG_FIND_HI: begin
                    for (int j = 8; j < 16; j++) begin
                        if (j < FIND_MAX) r_find[FIW'(j)] <= i_cfg_wdata[8*(j-8) +: 8];
                    end
                end
                REG_FIND_LEN: r_flen <= w_flen_clamp;
                REG_SUB_LO: begin
                    for (int j = 0; j < 8; j++) begin
                        if (j < SUBST_MAX) r_subst[SIW'(j)] <= i_cfg_wdata[8*j +: 8];
                    end
                end
                REG_SUB_HI: begin
                    for (int j = 8; j < 16; j++) begin
                        if (j < SUBST_MAX) r_subst[SIW'(j)] <= i_cfg_wdata[8*(j-8) +: 8];
                    end
                end
                REG_SUB_LEN: r_slen <= w_slen_clamp;
                default: ;
            endcase
        end
    end

    assign w_rem_next = r_rem - FLW'(1);
    assign w_emit     = i_cmd.emit_window | i_cmd.emit_subst;

    // A shift is accepted once the window bytes left after dropping the head
    // are again a prefix of the pattern.
    always_comb begin
        w_cand_ok = 1'b1;
        for (int k = 0; k < WIN - 1; k++) begin
            if ((FLW'(k) < w_rem_next) && (r_win[k+1] != r_find[FIW'(k)])) begin
                w_cand_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_match) begin
                r_match <= '0;
            end else if (i_cmd.advance) begin
                r_match <= r_match + FLW'(1);
            end else if (i_cmd.commit_shift) begin
                r_match <= w_rem_next;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_char) begin
            r_char <= i_char;
        end
        // The window holds the partially matched pattern bytes followed by the word.
        if (i_cmd.load_window) begin
            for (int j = 0; j < WIN; j++) begin
                r_win[j] <= (FLW'(j) < r_match) ? r_find[FIW'(j)] : r_char;
            end
            r_rem <= r_match + FLW'(1);
        end else if (i_cmd.emit_window) begin
            for (int j = 0; j < WIN - 1; j++) begin
                r_win[j] <= r_win[j+1];
            end
            r_rem <= w_rem_next;
        end
        if (i_cmd.load_subst) begin
            r_sub_idx  <= '0;
            r_sub_left <= r_slen;
        end else if (i_cmd.emit_subst) begin
            r_sub_idx  <= r_sub_idx + SIW'(1);
            r_sub_left <= r_sub_left - SLW'(1);
        end
        if (i_cmd.emit_window) begin
            r_out_char <= r_win[0];
            r_out_last <= (r_char == '0) && (r_rem == FLW'(1));
        end else if (i_cmd.emit_subst) begin
            r_out_char <= r_subst[r_sub_idx];
            r_out_last <= 1'b0;
        end
    end

    always_comb begin
        o_status.is_term     = (r_char == '0);
        o_status.bypass      = (r_flen == '0) || (r_match >= r_flen);
        o_status.hit         = (r_find[r_match[FIW-1:0]] == r_char);
        o_status.full_match  = ((r_match + FLW'(1)) == r_flen);
        o_status.subst_empty = (r_slen == '0);
        o_status.out_ready   = !r_out_valid || i_out_ready;
        o_status.window_one  = (r_rem == FLW'(1));
        o_status.subst_one   = (r_sub_left == SLW'(1));
        o_status.cand_ok     = w_cand_ok;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

    `SFR_ASSERT_IMP(a_match_bound, 1'b1, r_match < FLW'(FIND_MAX), "partial match out of range")
    `SFR_ASSERT_NXT(a_emit_valid, w_emit, r_out_valid, "emitted word not presented")
    `SFR_ASSERT_IMP(a_window_nonempty, i_cmd.emit_window, r_rem != '0, "emit from empty window")

endmodule

`default_nettype wire

// ===== rtl/core/sfr_ctrl.sv =====
// Controller state machine sequencing evaluation, flush, shift and replacement.
`default_nettype none
`include "stream_find_and_replace_macros.svh"

module sfr_ctrl (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_s_valid,
    output logic                      o_s_ready,
    input  wire sfr_pkg::t_dp_status  i_status,
    output sfr_pkg::t_dp_cmd          o_cmd
);
    import sfr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_FLUSH,
        S_SHIFT,
        S_SUBST
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load_char = 1'b1;
                    n_state         = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.is_term || i_status.bypass) begin
                    o_cmd.load_window = 1'b1;
                    o_cmd.clear_match = 1'b1;
                    n_state           = S_FLUSH;
                end else if (i_status.hit) begin
                    if (i_status.full_match) begin
                        o_cmd.clear_match = 1'b1;
                        if (!i_status.subst_empty) begin
                            o_cmd.load_subst = 1'b1;
                            n_state          = S_SUBST;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else begin
                    o_cmd.load_window = 1'b1;
                    n_state           = S_SHIFT;
                end
            end
            S_FLUSH: begin
                if (i_status.out_ready) begin
                    o_cmd.emit_window = 1'b1;
                    if (i_status.window_one) n_state = S_IDLE;
                end
            end
            S_SHIFT: begin
                // One word leaves the window per cycle, while the output has room, until the rest realigns.
                if (i_status.out_ready) begin
                    o_cmd.emit_window = 1'b1;
                    if (i_status.cand_ok) begin
                        o_cmd.commit_shift = 1'b1;
                        n_state            = S_IDLE;
                    end
                end
            end
            S_SUBST: begin
                if (i_status.out_ready) begin
                    o_cmd.emit_subst = 1'b1;
                    if (i_status.subst_one) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_s_ready = r_ready;

    `SFR_ASSERT_IMP(a_emit_room, o_cmd.emit_window || o_cmd.emit_subst, i_status.out_ready, "emit with full output")
    `SFR_ASSERT_NXT(a_accept_eval, i_s_valid && o_s_ready, r_state == S_EVAL, "accepted word not evaluated")
    `SFR_ASSERT_IMP(a_ready_idle, 1'b1, r_ready == (r_state == S_IDLE), "ready out of step with state")

endmodule

`default_nettype wire

// ===== rtl/core/stream_find_and_replace.sv =====
// Top level of the streaming find-and-replace block.
//
//   Channel   Direction  Handshake                        Contents
//   s_axis    in         s_axis_tvalid / s_axis_tready    one string byte per word
//   m_axis    out        m_axis_tvalid / m_axis_tready    rewritten byte, tlast on final zero
//   cfg       in         i_cfg_we (no back-pressure)      register index and write data
//
// An input word is accepted, then evaluated; the output words it causes then come from
// the window shifter or the replacement counter. Stalls on m_axis hold the sequencer in place.
// Reset clears the partial match, all configuration registers and the output valid.
// s_axis_tready is high only between words, while an earlier output may still wait.
`default_nettype none

module stream_find_and_replace #(
    parameter int FIND_MAX  = sfr_pkg::FIND_MAX_DEF,
    parameter int SUBST_MAX = sfr_pkg::SUBST_MAX_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [sfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [sfr_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire  [7:0]                      s_axis_tdata,  // [7:0] char_in
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // [7:0] char_out
    output logic                            m_axis_tlast   // end_of_string
);
    import sfr_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    sfr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    sfr_datapath #(
        .FIND_MAX  (FIND_MAX),
        .SUBST_MAX (SUBST_MAX)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_char      (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_char  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire
